// File: sv/ptst_pkg.sv
// Shared types and constants for the periodic timer slot table.
package ptst_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = 5;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_DEL   = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_NOMATCH = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        RESP_OK_CNT,
        RESP_OK_IDX,
        RESP_OK_ZERO,
        RESP_FULL,
        RESP_NOMATCH,
        RESP_PEND_MID,
        RESP_TICK_END
    } t_resp;

    typedef struct packed {
        logic  latch;
        logic  idx_inc;
        logic  cnt_inc;
        logic  cnt_dec;
        logic  cnt_clr;
        logic  wr_tick;
        logic  wr_add;
        logic  wr_shift;
        logic  pend_cap;
        logic  emit;
        t_resp resp;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  enabled;
        logic  idx_last;
        logic  cnt_zero;
        logic  full;
        logic  match;
        logic  fire;
        logic  pend_v;
        logic  nfire_max;
        logic  out_free;
    } t_stat;

endpackage

// File: sv/ptst_ctrl.sv
// Controller state machine that sequences each operation over the table.
module ptst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ptst_pkg::t_stat i_stat,
    output ptst_pkg::t_cmd  o_cmd,
    output logic           o_idle
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_T_EVAL,
        S_T_DONE,
        S_ADD,
        S_D_EVAL,
        S_D_MISS,
        S_SHIFT,
        S_RESP_OK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_push;

    assign o_idle = (r_state == S_IDLE);
    assign w_push = i_stat.fire && !i_stat.nfire_max;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.resp = ptst_pkg::RESP_OK_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.kind)
                    ptst_pkg::KIND_TICK: begin
                        n_state = (i_stat.enabled && !i_stat.cnt_zero) ? S_T_EVAL : S_T_DONE;
                    end
                    ptst_pkg::KIND_ADD: begin
                        n_state = S_ADD;
                    end
                    ptst_pkg::KIND_DEL: begin
                        n_state = i_stat.cnt_zero ? S_D_MISS : S_D_EVAL;
                    end
                    default: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state = S_RESP_OK;
                    end
                endcase
            end
            S_T_EVAL: begin
                if (!(w_push && i_stat.pend_v && !i_stat.out_free)) begin
                    o_cmd.wr_tick = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    if (w_push) begin
                        o_cmd.pend_cap = 1'b1;
                        o_cmd.emit = i_stat.pend_v;
                        o_cmd.resp = ptst_pkg::RESP_PEND_MID;
                    end
                    if (i_stat.idx_last) begin
                        n_state = S_T_DONE;
                    end
                end
            end
            S_T_DONE: begin
                o_cmd.resp = ptst_pkg::RESP_TICK_END;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ADD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                    if (i_stat.full) begin
                        o_cmd.resp = ptst_pkg::RESP_FULL;
                    end else begin
                        o_cmd.resp = ptst_pkg::RESP_OK_CNT;
                        o_cmd.wr_add = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            S_D_EVAL: begin
                o_cmd.resp = ptst_pkg::RESP_OK_IDX;
                if (i_stat.match) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.idx_inc = 1'b1;
                        if (i_stat.idx_last) begin
                            o_cmd.cnt_dec = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_SHIFT;
                        end
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_D_MISS;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_D_MISS: begin
                o_cmd.resp = ptst_pkg::RESP_NOMATCH;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RESP_OK: begin
                o_cmd.resp = ptst_pkg::RESP_OK_ZERO;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/ptst_dp.sv
// Datapath with the entry memory, fill count, walk index and result register.
module ptst_dp #(
    parameter int SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptst_pkg::t_cmd      i_cmd,
    output ptst_pkg::t_stat     o_stat,
    input  logic [1:0]          i_kind,
    input  logic [31:0]         i_handle,
    input  logic signed [31:0]  i_arg,
    input  logic [31:0]         i_period,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_fired,
    output logic [31:0]         o_fired_handle,
    output logic signed [31:0]  o_fired_arg,
    output logic [3:0]          o_slot,
    output logic [1:0]          o_status,
    output logic                o_last
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef struct packed {
        logic [31:0]        handle;
        logic signed [31:0] arg;
        logic [31:0]        period;
        logic [31:0]        remaining;
    } t_entry;

    t_entry r_mem [SLOTS];
    t_entry r_rd;
    t_entry w_wdata;
    logic   w_wen;
    logic [CW-1:0] w_waddr;
    logic [CW-1:0] w_raddr;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] w_idx_p1;
    logic [ptst_pkg::FIRE_CNT_W-1:0] r_nfire;
    logic          r_enabled;

    ptst_pkg::t_kind    r_kind;
    logic [31:0]        r_handle;
    logic signed [31:0] r_arg;
    logic [31:0]        r_period;

    logic               r_pend_v;
    logic [31:0]        r_pend_h;
    logic signed [31:0] r_pend_a;
    logic [3:0]         r_pend_slot;

    logic               r_ov;
    logic               w_out_free;

    logic               n_fired;
    logic [31:0]        n_fired_handle;
    logic signed [31:0] n_fired_arg;
    logic [3:0]         n_slot;
    logic [1:0]         n_status;
    logic               n_last;

    assign w_idx_p1   = r_idx + CW'(1);
    assign w_out_free = !r_ov || !i_out_stall;

    always_comb begin
        o_stat.kind      = r_kind;
        o_stat.enabled   = r_enabled;
        o_stat.idx_last  = (w_idx_p1 == r_count);
        o_stat.cnt_zero  = (r_count == '0);
        o_stat.full      = (r_count == CW'(SLOTS));
        o_stat.match     = (r_rd.handle != 32'd0) && (r_rd.handle == r_handle) &&
                           (r_rd.arg == r_arg);
        o_stat.fire      = (r_rd.remaining == 32'd0);
        o_stat.pend_v    = r_pend_v;
        o_stat.nfire_max = (r_nfire == ptst_pkg::FIRE_CNT_W'(ptst_pkg::MAX_RESULTS));
        o_stat.out_free  = w_out_free;
    end

    always_comb begin
        w_raddr = i_cmd.idx_inc ? w_idx_p1 : r_idx;
        w_wen   = i_cmd.wr_tick || i_cmd.wr_add || i_cmd.wr_shift;
        w_wdata = r_rd;
        w_waddr = r_idx;
        if (i_cmd.wr_add) begin
            w_waddr = r_count;
            w_wdata = '{handle: r_handle, arg: r_arg, period: r_period,
                        remaining: r_period};
        end else if (i_cmd.wr_shift) begin
            w_waddr = r_idx - CW'(1);
        end else if (r_rd.remaining == 32'd0) begin
            w_wdata.remaining = r_rd.period;
        end else begin
            w_wdata.remaining = r_rd.remaining - 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[w_waddr[IW-1:0]] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr[IW-1:0]];
    end

    always_comb begin
        n_fired        = 1'b0;
        n_fired_handle = 32'd0;
        n_fired_arg    = 32'sd0;
        n_slot         = 4'd0;
        n_status       = ptst_pkg::STATUS_OK;
        n_last         = 1'b1;
        case (i_cmd.resp)
            ptst_pkg::RESP_OK_CNT:  n_slot = 4'(r_count);
            ptst_pkg::RESP_OK_IDX:  n_slot = 4'(r_idx);
            ptst_pkg::RESP_FULL:    n_status = ptst_pkg::STATUS_FULL;
            ptst_pkg::RESP_NOMATCH: n_status = ptst_pkg::STATUS_NOMATCH;
            ptst_pkg::RESP_PEND_MID, ptst_pkg::RESP_TICK_END: begin
                if (r_pend_v) begin
                    n_fired        = 1'b1;
                    n_fired_handle = r_pend_h;
                    n_fired_arg    = r_pend_a;
                    n_slot         = r_pend_slot;
                end
                n_last = (i_cmd.resp == ptst_pkg::RESP_TICK_END);
            end
            default: begin
                n_slot = 4'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind   <= ptst_pkg::t_kind'(i_kind);
            r_handle <= i_handle;
            r_arg    <= i_arg;
            r_period <= i_period;
        end
        if (i_cmd.pend_cap) begin
            r_pend_h    <= r_rd.handle;
            r_pend_a    <= r_rd.arg;
            r_pend_slot <= 4'(r_idx);
        end
        if (i_cmd.emit) begin
            o_fired        <= n_fired;
            o_fired_handle <= n_fired_handle;
            o_fired_arg    <= n_fired_arg;
            o_slot         <= n_slot;
            o_status       <= n_status;
            o_last         <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_nfire   <= '0;
            r_enabled <= 1'b0;
            r_pend_v  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_enabled <= i_cfg_data;
            end
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc && r_handle != 32'd0) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.latch) begin
                r_idx    <= '0;
                r_nfire  <= '0;
                r_pend_v <= 1'b0;
            end else begin
                if (i_cmd.idx_inc) begin
                    r_idx <= w_idx_p1;
                end
                if (i_cmd.pend_cap) begin
                    r_pend_v <= 1'b1;
                    r_nfire  <= r_nfire + ptst_pkg::FIRE_CNT_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;

endmodule

// File: sv/periodic_timer_slot_table.sv
// Top level: one item at a time; add and clear go through decode and then a result state that registers the result.
// A tick walks the occupied entries through the entry memory at one entry per cycle unless a stalled output holds it.
// A delete searches one entry per cycle and then shifts later entries down one per cycle.
// A result waits in the output register while stalled and holds the walk when the next is due.
// Reset empties the table by zeroing the fill count at once, with no clearing pass,
// and leaves the timers disabled.
module periodic_timer_slot_table #(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [31:0]        i_handle,
    input  logic signed [31:0] i_arg,
    input  logic [31:0]        i_period,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_fired,
    output logic [31:0]        o_fired_handle,
    output logic signed [31:0] o_fired_arg,
    output logic [3:0]         o_slot,
    output logic [1:0]         o_status,
    output logic               o_last
);

    ptst_pkg::t_cmd  w_cmd;
    ptst_pkg::t_stat w_stat;
    logic            w_idle;

    assign o_in_stall  = !w_idle;
    assign o_cfg_ready = 1'b1;

    ptst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle)
    );

    ptst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_kind         (i_kind),
        .i_handle       (i_handle),
        .i_arg          (i_arg),
        .i_period       (i_period),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_fired        (o_fired),
        .o_fired_handle (o_fired_handle),
        .o_fired_arg    (o_fired_arg),
        .o_slot         (o_slot),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule
